// File: hdl/ffca_pkg.sv
`timescale 1ns / 1ps
package ffca_pkg;

  typedef enum logic [1:0] {
    ACT_PERM    = 2'd0,
    ACT_TEMP    = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_BAD     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_INVALID = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] size_words;
    logic [15:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [15:0] address;
    logic [1:0]  status;
    logic [16:0] words_in_use;
  } out_item_t;

  localparam logic [2:0] SLACK_RESET = 3'd2;
  localparam logic [1:0] SLACK_ADDR  = 2'b00;

endpackage

// File: hdl/first_fit_coalescing_allocator.sv
`timescale 1ns / 1ps
// Channel  | Ports                        | Transfer
// input    | in_start, in_busy, in_item   | start high while busy low
// result   | out_valid, out_item          | one cycle strobe, no stall
// config   | cfg_psel .. cfg_pready       | APB access with pready high
// A permanent allocate passes through S_DISP and S_DONE. A temporary allocate
// searches the segment table one entry per cycle, a release walks it through
// S_WALK and S_RLWAIT for each entry, and shifting entries on removal or
// insertion passes through S_SHWR and S_SHRD for each entry. Busy stays high
// until the result strobe. Reset is synchronous and needs no clearing pass. The
// receiver cannot stall.
module first_fit_coalescing_allocator #(
  parameter int HEAP_WORDS   = 65536,
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_start,
  output logic                in_busy,
  input  ffca_pkg::in_item_t  in_item,
  output logic                out_valid,
  output ffca_pkg::out_item_t out_item,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [1:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int HAW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
  localparam int SAW = $clog2(MAX_SEGMENTS);
  localparam int CW  = SAW + 1;
  localparam logic [16:0] HEAP17 = 17'(HEAP_WORDS);
  localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DISP   = 11'b00000000010,
    S_SRCH   = 11'b00000000100,
    S_HRD    = 11'b00000001000,
    S_HCHK   = 11'b00000010000,
    S_WALK   = 11'b00000100000,
    S_SHRD   = 11'b00001000000,
    S_SHWR   = 11'b00010000000,
    S_DONE   = 11'b00100000000,
    S_RLWAIT = 11'b01000000000,
    S_FIN    = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  ffca_pkg::in_item_t req_r, req_nxt;
  logic [2:0]  slack_r, slack_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [16:0] glow_r, glow_nxt, ghigh_r, ghigh_nxt, free_r, free_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] end_r, end_nxt;
  logic        dir_r, dir_nxt;
  logic [15:0] f_r, f_nxt;
  logic [16:0] sz_r, sz_nxt;
  logic [32:0] prev_r, prev_nxt;
  logic        havep_r, havep_nxt;
  logic [32:0] pend_r, pend_nxt;
  logic        pendv_r, pendv_nxt;
  logic        ov_r, ov_nxt;
  logic [15:0] oaddr_r, oaddr_nxt;
  logic [1:0]  ost_r, ost_nxt;

  logic        hwe;
  logic [HAW-1:0] hwa, hra;
  logic [16:0] hwd, hrd;
  logic        swe;
  logic [SAW-1:0] swa, sra;
  logic [32:0] swd, srd;

  ffca_hdr_mem #(.AW(HAW)) u_hdr (
    .clk(clk), .we(hwe), .waddr(hwa), .wdata(hwd), .raddr(hra), .rdata(hrd)
  );
  ffca_seg_mem #(.AW(SAW)) u_seg (
    .clk(clk), .we(swe), .waddr(swa), .wdata(swd), .raddr(sra), .rdata(srd)
  );

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {29'd0, slack_r};
  assign in_busy    = (state_r != S_IDLE);
  assign out_valid  = ov_r;
  assign out_item.address      = oaddr_r;
  assign out_item.status       = ost_r;
  assign out_item.words_in_use = HEAP17 - free_r - (ghigh_r - glow_r);

  logic [16:0] n17, seg_sz, rem, hdr_end;
  logic [15:0] seg_st;
  logic [16:0] f_end;
  logic        lower, upper;

  always_comb begin
    n17    = {1'b0, req_r.size_words} + 17'd1;
    seg_st = srd[32:17];
    seg_sz = srd[16:0];
    rem    = seg_sz - n17;
    hdr_end = HEAP17 - {1'b0, f_r};
    f_end  = {1'b0, f_r} + sz_r;
    lower  = havep_r &&
             (({2'b00, prev_r[32:17]} + {1'b0, prev_r[16:0]}) == {2'b00, f_r});
    upper  = (idx_r < cnt_r) && !pendv_r && (f_end == {1'b0, seg_st});
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    slack_nxt = slack_r;
    cnt_nxt = cnt_r;
    glow_nxt = glow_r;
    ghigh_nxt = ghigh_r;
    free_nxt = free_r;
    idx_nxt = idx_r;
    end_nxt = end_r;
    dir_nxt = dir_r;
    f_nxt = f_r;
    sz_nxt = sz_r;
    prev_nxt = prev_r;
    havep_nxt = havep_r;
    pend_nxt = pend_r;
    pendv_nxt = pendv_r;
    ov_nxt = 1'b0;
    oaddr_nxt = oaddr_r;
    ost_nxt = ost_r;
    hwe = 1'b0;
    hwa = '0;
    hwd = '0;
    hra = HAW'(req_r.block_address - 16'd1);
    swe = 1'b0;
    swa = '0;
    swd = '0;
    sra = idx_r[SAW-1:0];

    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ffca_pkg::SLACK_ADDR) begin
      slack_nxt = cfg_pwdata[2:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_start) begin
          req_nxt = in_item;
          idx_nxt = '0;
          sra = '0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        oaddr_nxt = '0;
        ost_nxt = ffca_pkg::ST_INVALID;
        havep_nxt = 1'b0;
        pendv_nxt = 1'b0;
        case (ffca_pkg::action_t'(req_r.action))
          ffca_pkg::ACT_PERM: begin
            if (req_r.size_words == '0) begin
              state_nxt = S_DONE;
            end else if ((ghigh_r - glow_r) < {1'b0, req_r.size_words}) begin
              ost_nxt = ffca_pkg::ST_OOM;
              state_nxt = S_DONE;
            end else begin
              ghigh_nxt = ghigh_r - {1'b0, req_r.size_words};
              oaddr_nxt = ghigh_nxt[15:0];
              ost_nxt = ffca_pkg::ST_OK;
              state_nxt = S_DONE;
            end
          end
          ffca_pkg::ACT_TEMP: begin
            if (req_r.size_words == '0) state_nxt = S_DONE;
            else state_nxt = S_SRCH;
          end
          ffca_pkg::ACT_RELEASE: begin
            if (req_r.block_address == '0 ||
                {1'b0, req_r.block_address - 16'd1} >= HEAP17) begin
              state_nxt = S_DONE;
            end else begin
              f_nxt = req_r.block_address - 16'd1;
              state_nxt = S_HRD;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SRCH: begin
        // srd holds entry idx_r
        if (idx_r >= cnt_r) begin
          if ((ghigh_r - glow_r) < n17) begin
            ost_nxt = ffca_pkg::ST_OOM;
          end else begin
            hwe = 1'b1;
            hwa = HAW'(glow_r);
            hwd = n17;
            oaddr_nxt = glow_r[15:0] + 16'd1;
            glow_nxt = glow_r + n17;
            ost_nxt = ffca_pkg::ST_OK;
          end
          state_nxt = S_DONE;
        end else if (seg_sz >= n17) begin
          ost_nxt = ffca_pkg::ST_OK;
          if (rem <= {14'd0, slack_r}) begin
            hwe = 1'b1;
            hwa = HAW'(seg_st);
            hwd = seg_sz;
            oaddr_nxt = seg_st + 16'd1;
            free_nxt = free_r - seg_sz;
            end_nxt = cnt_r - CW'(1);
            dir_nxt = 1'b0;
            cnt_nxt = cnt_r - CW'(1);
            if (idx_r + CW'(1) >= cnt_r) begin
              state_nxt = S_DONE;
            end else begin
              sra = SAW'(idx_r + CW'(1));
              state_nxt = S_SHWR;
            end
          end else begin
            hwe = 1'b1;
            hwa = HAW'(17'({1'b0, seg_st} + rem));
            hwd = n17;
            oaddr_nxt = 16'(17'({1'b0, seg_st} + rem + 17'd1));
            free_nxt = free_r - n17;
            swe = 1'b1;
            swa = idx_r[SAW-1:0];
            swd = {seg_st, rem};
            state_nxt = S_DONE;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
          sra = SAW'(idx_r + CW'(1));
        end
      end
      S_HRD: begin
        hra = HAW'(f_r);
        state_nxt = S_HCHK;
      end
      S_HCHK: begin
        if (hrd == '0 || hrd > hdr_end) begin
          state_nxt = S_DONE;
        end else begin
          sz_nxt = hrd;
          idx_nxt = '0;
          sra = '0;
          state_nxt = S_RLWAIT;
        end
      end
      S_RLWAIT: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        // The first entry is passed whenever its start does not lie above the block.
        if (idx_r < cnt_r &&
            (seg_st < f_r || (idx_r == '0 && seg_st == f_r))) begin
          prev_nxt = srd;
          havep_nxt = 1'b1;
          idx_nxt = idx_r + CW'(1);
          sra = SAW'(idx_r + CW'(1));
          state_nxt = S_RLWAIT;
        end else begin
          ost_nxt = ffca_pkg::ST_OK;
          if (lower && upper) begin
            swe = 1'b1;
            swa = SAW'(idx_r - CW'(1));
            swd = {prev_r[32:17], 17'(prev_r[16:0] + sz_r + seg_sz)};
            free_nxt = free_r + sz_r;
            cnt_nxt = cnt_r - CW'(1);
            dir_nxt = 1'b0;
            if (idx_r + CW'(1) >= cnt_r) begin
              state_nxt = S_DONE;
            end else begin
              sra = SAW'(idx_r + CW'(1));
              state_nxt = S_SHWR;
            end
          end else if (lower) begin
            swe = 1'b1;
            swa = SAW'(idx_r - CW'(1));
            swd = {prev_r[32:17], 17'(prev_r[16:0] + sz_r)};
            free_nxt = free_r + sz_r;
            state_nxt = S_DONE;
          end else if (upper) begin
            swe = 1'b1;
            swa = idx_r[SAW-1:0];
            swd = {f_r, 17'(seg_sz + sz_r)};
            free_nxt = free_r + sz_r;
            state_nxt = S_DONE;
          end else if (cnt_r >= MAXC) begin
            ost_nxt = ffca_pkg::ST_FULL;
            state_nxt = S_DONE;
          end else begin
            free_nxt = free_r + sz_r;
            dir_nxt = 1'b1;
            end_nxt = idx_r;
            cnt_nxt = cnt_r + CW'(1);
            if (idx_r == cnt_r) begin
              swe = 1'b1;
              swa = idx_r[SAW-1:0];
              swd = {f_r, sz_r};
              state_nxt = S_DONE;
            end else begin
              idx_nxt = cnt_r - CW'(1);
              sra = SAW'(cnt_r - CW'(1));
              state_nxt = S_SHWR;
            end
          end
        end
      end
      S_SHRD: begin
        if (!dir_r) begin
          sra = SAW'(idx_r + CW'(1));
        end
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        swe = 1'b1;
        if (dir_r) begin
          // open a hole: move entry idx up by one, walking down
          swa = SAW'(idx_r + CW'(1));
          swd = srd;
          if (idx_r == end_r) begin
            pend_nxt = {f_r, sz_r};
            pendv_nxt = 1'b1;
            state_nxt = S_FIN;
          end else begin
            idx_nxt = idx_r - CW'(1);
            sra = SAW'(idx_r - CW'(1));
            state_nxt = S_SHRD;
          end
        end else begin
          // close a hole: move entry idx+1 down to idx, walking up
          swa = idx_r[SAW-1:0];
          swd = srd;
          if (idx_r + CW'(1) >= cnt_r) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + CW'(1);
            sra = SAW'(idx_r + CW'(2));
            state_nxt = S_SHRD;
          end
        end
      end
      S_FIN: begin
        swe = 1'b1;
        swa = end_r[SAW-1:0];
        swd = pend_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slack_r <= ffca_pkg::SLACK_RESET;
      cnt_r   <= '0;
      glow_r  <= '0;
      ghigh_r <= HEAP17;
      free_r  <= '0;
      ov_r    <= 1'b0;
      havep_r <= 1'b0;
      pendv_r <= 1'b0;
      dir_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slack_r <= slack_nxt;
      cnt_r   <= cnt_nxt;
      glow_r  <= glow_nxt;
      ghigh_r <= ghigh_nxt;
      free_r  <= free_nxt;
      ov_r    <= ov_nxt;
      havep_r <= havep_nxt;
      pendv_r <= pendv_nxt;
      dir_r   <= dir_nxt;
    end
    req_r   <= req_nxt;
    idx_r   <= idx_nxt;
    end_r   <= end_nxt;
    f_r     <= f_nxt;
    sz_r    <= sz_nxt;
    prev_r  <= prev_nxt;
    pend_r  <= pend_nxt;
    oaddr_r <= oaddr_nxt;
    ost_r   <= ost_nxt;
  end

endmodule

// File: hdl/ffca_hdr_mem.sv
`timescale 1ns / 1ps
module ffca_hdr_mem #(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [16:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [16:0]   rdata
);

  logic [16:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/ffca_seg_mem.sv
`timescale 1ns / 1ps
module ffca_seg_mem #(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [32:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [32:0]   rdata
);

  logic [32:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
